### rtl/core/slcs_pkg.sv
// Shared types, widths and rounding helpers for the scalar LSTM cell step.
// Used by every module under rtl/core; depends on nothing.
`timescale 1ns / 1ps

package slcs_pkg;

	// Number format and storage widths
	localparam int DATA_WIDTH = 16;
	localparam int FRAC_BITS  = 12;
	localparam int CELL_W     = 24;
	localparam int OUT_W      = 14;
	localparam int COEF_W     = 3 * DATA_WIDTH;
	localparam int NUM_GATES  = 4;

	// Datapath widths
	localparam int ACC_W  = 2 * DATA_WIDTH + 2;
	localparam int MUL_A_W = CELL_W;
	localparam int MUL_B_W = DATA_WIDTH;
	localparam int PROD_W = MUL_A_W + MUL_B_W;
	localparam int ACT_W  = CELL_W + 2;
	localparam int SIG_W  = FRAC_BITS + 1;
	localparam int ACTO_W = FRAC_BITS + 2;

	// Gate codes, also the register index of each gate's coefficients
	localparam logic [1:0] GATE_FORGET = 2'd0;
	localparam logic [1:0] GATE_CAND   = 2'd1;
	localparam logic [1:0] GATE_INPUT  = 2'd2;
	localparam logic [1:0] GATE_OUTPUT = 2'd3;

	// Request to the shared multiplier
	typedef struct packed {
		logic                       en;
		logic signed [MUL_A_W-1:0] a;
		logic signed [MUL_B_W-1:0] b;
	} mul_req_t;

	// Request to the shared activation unit
	typedef struct packed {
		logic signed [ACT_W-1:0] a;
		logic                    tanh_mode;
	} act_req_t;

	localparam logic signed [ACC_W-1:0]  ACC_HALF  = ACC_W'(1) <<< (FRAC_BITS - 1);
	localparam logic signed [PROD_W-1:0] PROD_HALF = PROD_W'(1) <<< (FRAC_BITS - 1);

	// Round half up and drop the extra fraction bits of an accumulator value
	function automatic logic signed [ACC_W-1:0] round_acc(input logic signed [ACC_W-1:0] v);
		logic signed [ACC_W-1:0] t;
		t = v + ACC_HALF;
		return t >>> FRAC_BITS;
	endfunction

	// Round half up and drop the extra fraction bits of a product
	function automatic logic signed [PROD_W-1:0] round_prod(input logic signed [PROD_W-1:0] v);
		logic signed [PROD_W-1:0] t;
		t = v + PROD_HALF;
		return t >>> FRAC_BITS;
	endfunction

endpackage

### rtl/core/slcs_mul.sv
// Shared signed multiplier with registered product.
// Depends on slcs_pkg for operand widths and the request struct.
`timescale 1ns / 1ps

module slcs_mul import slcs_pkg::*; (
	input  logic                      clk,
	input  mul_req_t                  req,
	output logic signed [PROD_W-1:0] prod_q
);

	// Capture a new product only when a multiply is issued; hold otherwise
	always_ff @(posedge clk) begin
		if (req.en) begin
			prod_q <= PROD_W'(req.a) * PROD_W'(req.b);
		end
	end

endmodule

### rtl/core/slcs_act.sv
// Shared piecewise-linear sigmoid / tanh unit, purely combinational.
// Depends on slcs_pkg for widths and the request struct.
`timescale 1ns / 1ps

module slcs_act import slcs_pkg::*; (
	input  act_req_t                  req,
	output logic signed [ACTO_W-1:0] y
);

	localparam logic [ACT_W-1:0] ONE_U    = ACT_W'(1) << FRAC_BITS;
	localparam logic [ACT_W-1:0] SAT_LIM  = ACT_W'(5) << FRAC_BITS;
	localparam logic [ACT_W-1:0] KNEE_HI  = ACT_W'((19 << FRAC_BITS) / 8);
	localparam logic [ACT_W-1:0] OFF_HI   = ACT_W'((27 << FRAC_BITS) >> 5);
	localparam logic [ACT_W-1:0] OFF_MID  = ACT_W'((5 << FRAC_BITS) >> 3);
	localparam logic [ACT_W-1:0] OFF_LO   = ACT_W'(1) << (FRAC_BITS - 1);
	localparam logic [SIG_W-1:0] ONE_S    = SIG_W'(1) << FRAC_BITS;
	localparam logic signed [ACTO_W:0] ONE_T = (ACTO_W + 1)'(1) <<< FRAC_BITS;

	logic signed [ACT_W-1:0] arg;
	logic                    neg;
	logic [ACT_W-1:0]        u;
	logic [ACT_W-1:0]        yw;
	logic [SIG_W-1:0]        yu;
	logic [SIG_W-1:0]        s;
	logic signed [ACTO_W:0]  t2;

	always_comb begin
		// tanh(a) is taken as 2*sig(2a) - 1
		arg = req.tanh_mode ? (req.a <<< 1) : req.a;
		neg = arg[ACT_W-1];
		u   = neg ? (~arg + ACT_W'(1)) : arg;

		// Pick the segment on the magnitude
		if (u >= SAT_LIM) begin
			yw = ONE_U;
		end else if (u >= KNEE_HI) begin
			yw = (u >> 5) + OFF_HI;
		end else if (u >= ONE_U) begin
			yw = (u >> 3) + OFF_MID;
		end else begin
			yw = (u >> 2) + OFF_LO;
		end
		yu = yw[SIG_W-1:0];

		// Mirror for negative inputs
		s = neg ? (ONE_S - yu) : yu;

		t2 = ($signed({2'b00, s}) <<< 1) - ONE_T;
		y  = req.tanh_mode ? t2[ACTO_W-1:0] : $signed({1'b0, s});
	end

endmodule

### rtl/core/scalar_lstm_cell_step.sv
// Top level of the one-unit LSTM cell forward step: sequencer, state and
// coefficient registers. Depends on slcs_pkg, slcs_mul and slcs_act.
`timescale 1ns / 1ps

// Usage
//   Input channel: in_valid / in_stall / x_sample (signed Q4.12). A sample
//   transfers when in_valid is high and in_stall low. in_stall is high while
//   a sample is being worked on.
//   Output channel: out_valid / out_stall / hidden_out (signed Q2.12, within
//   -1.0 .. +1.0). One result per sample, held in an output register until
//   the receiver transfers it.
//   Configuration: cfg_we / cfg_index / cfg_data write one 48-bit coefficient
//   register per cycle (0 forget, 1 candidate, 2 input, 3 output gate; each
//   packs bias[47:32], input weight[31:16], hidden weight[15:0]). Write only
//   while no sample is in flight.
//   Sequence: one multiplier and one activation unit are shared by all steps.
//   The S_GATE steps form the four gate sums; S_SCALE, S_CPROD, S_CSUM,
//   S_TANH, S_HMUL and S_HOUT then update the cell and hidden values. A new
//   sample is taken only once the sequencer is back in S_IDLE.
//   Stall: if the previous result is still waiting at the final step, the
//   sequencer holds there until the receiver takes it.
//   Reset: arst_n clears coefficients, cell and hidden values and drops
//   out_valid; the block leaves reset idle and ready for a sample.

module scalar_lstm_cell_step import slcs_pkg::*; (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [1:0]                    cfg_index,
	input  logic [COEF_W-1:0]             cfg_data,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic signed [DATA_WIDTH-1:0] x_sample,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic signed [OUT_W-1:0]      hidden_out
);

	typedef enum logic [7:0] {
		S_IDLE  = 8'b0000_0001,
		S_GATE  = 8'b0000_0010,
		S_SCALE = 8'b0000_0100,
		S_CPROD = 8'b0000_1000,
		S_CSUM  = 8'b0001_0000,
		S_TANH  = 8'b0010_0000,
		S_HMUL  = 8'b0100_0000,
		S_HOUT  = 8'b1000_0000
	} state_t;

	localparam logic [2:0] STEP_LAST = 3'd7;

	localparam logic signed [ACC_W-1:0]  CELL_MAX = ACC_W'((2 ** (CELL_W - 1)) - 1);
	localparam logic signed [ACC_W-1:0]  CELL_MIN = ACC_W'(-(2 ** (CELL_W - 1)));
	localparam logic signed [PROD_W-1:0] H_MAX    = PROD_W'((2 ** (DATA_WIDTH - 1)) - 1);
	localparam logic signed [PROD_W-1:0] H_MIN    = PROD_W'(-(2 ** (DATA_WIDTH - 1)));

	state_t                         state_q;
	logic [2:0]                     step_q;
	logic [COEF_W-1:0]              coef_q [NUM_GATES];
	logic signed [DATA_WIDTH-1:0]  x_q;
	logic signed [DATA_WIDTH-1:0]  h_q;
	logic signed [CELL_W-1:0]      c_q;
	logic signed [ACC_W-1:0]       acc_q;
	logic signed [ACTO_W-1:0]      act_q [NUM_GATES];
	logic                           out_valid_q;
	logic signed [OUT_W-1:0]       hidden_out_q;

	mul_req_t                       mul_req;
	act_req_t                       act_req;
	logic signed [PROD_W-1:0]      prod_q;
	logic signed [ACTO_W-1:0]      act_y;

	logic [1:0]                     gate_sel;
	logic [1:0]                     fin_idx;
	logic [COEF_W-1:0]              coef_cur;
	logic signed [DATA_WIDTH-1:0]  wh;
	logic signed [DATA_WIDTH-1:0]  wx;
	logic signed [DATA_WIDTH-1:0]  bias;
	logic signed [ACC_W-1:0]       bias_acc;
	logic signed [ACC_W-1:0]       prod_acc;
	logic signed [ACC_W-1:0]       preact;
	logic signed [PROD_W-1:0]      prod_rnd;
	logic signed [ACC_W-1:0]       c_sum;
	logic signed [CELL_W-1:0]      c_next;
	logic signed [DATA_WIDTH-1:0]  h_next;
	logic                           fire_out;

	slcs_mul u_mul (
		.clk    (clk),
		.req    (mul_req),
		.prod_q (prod_q)
	);

	slcs_act u_act (
		.req (act_req),
		.y   (act_y)
	);

	// Handshake outputs
	assign in_stall   = (state_q != S_IDLE);
	assign out_valid  = out_valid_q;
	assign hidden_out = hidden_out_q;
	assign fire_out   = (state_q == S_HOUT) && (!out_valid_q || !out_stall);

	// Unpack the coefficients of the gate being summed
	assign gate_sel = step_q[2:1];
	assign coef_cur = coef_q[gate_sel];
	assign wh       = $signed(coef_cur[0 +: DATA_WIDTH]);
	assign wx       = $signed(coef_cur[DATA_WIDTH +: DATA_WIDTH]);
	assign bias     = $signed(coef_cur[2 * DATA_WIDTH +: DATA_WIDTH]);
	assign bias_acc = $signed({{(ACC_W - DATA_WIDTH){bias[DATA_WIDTH-1]}}, bias}) <<< FRAC_BITS;
	assign fin_idx  = (state_q == S_SCALE) ? GATE_OUTPUT : (gate_sel - 2'd1);

	// Gate sum completion, cell update and hidden update
	assign prod_acc = $signed(prod_q[ACC_W-1:0]);
	assign preact   = round_acc(acc_q + prod_acc);
	assign prod_rnd = round_prod(prod_q);
	assign c_sum    = acc_q + $signed(prod_rnd[ACC_W-1:0]);

	always_comb begin
		if (c_sum > CELL_MAX) begin
			c_next = CELL_MAX[CELL_W-1:0];
		end else if (c_sum < CELL_MIN) begin
			c_next = CELL_MIN[CELL_W-1:0];
		end else begin
			c_next = c_sum[CELL_W-1:0];
		end
		if (prod_rnd > H_MAX) begin
			h_next = H_MAX[DATA_WIDTH-1:0];
		end else if (prod_rnd < H_MIN) begin
			h_next = H_MIN[DATA_WIDTH-1:0];
		end else begin
			h_next = prod_rnd[DATA_WIDTH-1:0];
		end
	end

	// Steer operands into the shared units
	always_comb begin
		mul_req.en        = 1'b0;
		mul_req.a         = '0;
		mul_req.b         = '0;
		act_req.a         = preact[ACT_W-1:0];
		act_req.tanh_mode = (fin_idx == GATE_CAND);
		case (state_q)
			S_GATE: begin
				mul_req.en = 1'b1;
				mul_req.a  = step_q[0] ? MUL_A_W'(x_q) : MUL_A_W'(h_q);
				mul_req.b  = step_q[0] ? wx : wh;
			end
			S_SCALE: begin
				mul_req.en = 1'b1;
				mul_req.a  = c_q;
				mul_req.b  = MUL_B_W'(act_q[GATE_FORGET]);
			end
			S_CPROD: begin
				mul_req.en = 1'b1;
				mul_req.a  = MUL_A_W'(act_q[GATE_INPUT]);
				mul_req.b  = MUL_B_W'(act_q[GATE_CAND]);
			end
			S_TANH: begin
				act_req.a         = ACT_W'(c_q);
				act_req.tanh_mode = 1'b1;
			end
			S_HMUL: begin
				mul_req.en = 1'b1;
				mul_req.a  = MUL_A_W'(act_q[GATE_OUTPUT]);
				mul_req.b  = MUL_B_W'(act_q[GATE_CAND]);
			end
			default: begin
			end
		endcase
	end

	// Sequencer, coefficients and recurrent state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			step_q      <= '0;
			h_q         <= '0;
			c_q         <= '0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < NUM_GATES; i++) begin
				coef_q[i] <= '0;
			end
		end else begin
			if (cfg_we) begin
				coef_q[cfg_index] <= cfg_data;
			end
			// Drop valid after a transfer unless a new result replaces it
			if (out_valid_q && !out_stall && !fire_out) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_GATE;
						step_q  <= '0;
					end
				end
				S_GATE: begin
					step_q <= step_q + 3'd1;
					if (step_q == STEP_LAST) begin
						state_q <= S_SCALE;
					end
				end
				S_SCALE: state_q <= S_CPROD;
				S_CPROD: state_q <= S_CSUM;
				S_CSUM: begin
					c_q     <= c_next;
					state_q <= S_TANH;
				end
				S_TANH: state_q <= S_HMUL;
				S_HMUL: state_q <= S_HOUT;
				S_HOUT: begin
					// Hold here while the previous result is still stalled
					if (fire_out) begin
						h_q         <= h_next;
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					x_q <= x_sample;
				end
			end
			S_GATE: begin
				if (!step_q[0]) begin
					acc_q <= bias_acc;
					if (step_q != 3'd0) begin
						act_q[fin_idx] <= act_y;
					end
				end else begin
					acc_q <= acc_q + prod_acc;
				end
			end
			S_SCALE: act_q[GATE_OUTPUT] <= act_y;
			S_CPROD: acc_q <= $signed(prod_rnd[ACC_W-1:0]);
			S_TANH:  act_q[GATE_CAND] <= act_y;
			S_HOUT: begin
				if (fire_out) begin
					hidden_out_q <= h_next[OUT_W-1:0];
				end
			end
			default: begin
			end
		endcase
	end

	// An accepted sample starts the gate sums at the first step
	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> (state_q == S_GATE && step_q == 3'd0))
		else $error("sample transfer did not start the gate sequence");

	// The gate phase ends after its last step
	a_gate_end: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_GATE && step_q == STEP_LAST) |=> (state_q == S_SCALE))
		else $error("gate phase did not hand over to cell update");

	// A result appears only from the final step
	a_out_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_HOUT))
		else $error("result raised outside the final step");

	// Hidden value changes only when a result is delivered
	a_h_update: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(h_q) |-> $past(fire_out))
		else $error("hidden value changed without a result");

	// Delivered result stays within plus or minus one
	a_out_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (hidden_out_q <= $signed(OUT_W'(4096))
			&& hidden_out_q >= $signed(-OUT_W'(4096))))
		else $error("hidden result out of range");

endmodule
